// ===== design/radix_digit_emitter_top_assert.svh =====
// ----------------------------------------------------------------------------
// radix_digit_emitter_top_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_EMITTER_TOP_ASSERT_SVH
`define RADIX_DIGIT_EMITTER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RDE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("radix digit emitter check failed");

// next-cycle implication, disabled while reset is asserted
`define RDE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("radix digit emitter check failed");

`endif

// ===== design/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// rde_pkg
// shared widths, codes and types of the radix digit emitter
// ----------------------------------------------------------------------------
package rde_pkg;

    localparam int VALUE_W         = 31;
    localparam int RADIX_W         = 6;
    localparam int DIGIT_W         = 6;
    localparam int DIGIT_DEPTH_DEF = 32;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    // tuser bit positions on the result side
    localparam int USER_EMPTY = 0;
    localparam int USER_BAD   = 1;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_FLAG
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== design/rde_ram.sv =====
// ----------------------------------------------------------------------------
// rde_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rde_ram import rde_pkg::*; #(
    parameter int WIDTH = DIGIT_W,
    parameter int DEPTH = DIGIT_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rde_divider.sv =====
// ----------------------------------------------------------------------------
// rde_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rde_divider import rde_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_dividend,
    input  logic [RADIX_W-1:0] i_divisor,
    output t_div_status        o_status,
    output logic [VALUE_W-1:0] o_quotient,
    output logic [RADIX_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [VALUE_W-1:0] r_quo, n_quo;
    logic [RADIX_W-1:0] r_rem, n_rem;
    logic [RADIX_W-1:0] r_div, n_div;

    logic [RADIX_W:0]   trial;
    logic               fits;

    // shift in the next dividend bit and try the subtraction
    assign trial = {r_rem, r_quo[VALUE_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[VALUE_W-2:0], fits};
            n_rem = fits ? RADIX_W'(trial - {1'b0, r_div}) : trial[RADIX_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;
    assign o_remainder   = r_rem;

endmodule

// ===== design/radix_digit_emitter_top.sv =====
// a flagged beat (bad radix or zero value) passes ST_FLAG and is offered from the output
// register once it is free; each digit takes one run of the divider, one quotient bit per
// cycle, and is pushed on the stack, then popped in ST_POP_RD and ST_POP_WAIT per digit;
// input ready only while idle, and the result register lets the next item in before the
// last digit beat is taken
// reset: synchronous active-low i_rst_n clears sequencer, stack level and output valid
// ----------------------------------------------------------------------------
// radix_digit_emitter_top
// converts a value to a base by repeated division, emits digits msd first
// ----------------------------------------------------------------------------
module radix_digit_emitter_top import rde_pkg::*; #(
    parameter int DIGIT_DEPTH = DIGIT_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input beat
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // [30:0] value, [36:31] radix, rest zero
    // result beat
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,   // [5:0] digit, rest zero
    output logic                 o_m_axis_tlast,   // last digit of this item
    output logic [M_TUSER_W-1:0] o_m_axis_tuser    // [0] empty_res, [1] bad_radix
);

    localparam int LVL_W = $clog2(DIGIT_DEPTH + 1);
    localparam int AW    = $clog2(DIGIT_DEPTH);

    // input fields
    logic [VALUE_W-1:0] in_value;
    logic [RADIX_W-1:0] in_radix;
    assign in_value = i_s_axis_tdata[VALUE_W-1:0];
    assign in_radix = i_s_axis_tdata[VALUE_W +: RADIX_W];

    t_state             r_state, n_state;
    logic [LVL_W-1:0]   r_level, n_level;   // number of digits on the stack
    logic [RADIX_W-1:0] r_radix, n_radix;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [DIGIT_W-1:0] r_digit, n_digit;
    logic               r_last, n_last;
    logic               r_empty, n_empty;
    logic               r_bad, n_bad;

    // pending flags for the single flagged beat
    logic               r_flag_empty, n_flag_empty;
    logic               r_flag_bad, n_flag_bad;

    // divider hookup
    logic               div_start;
    logic [VALUE_W-1:0] div_dividend;
    t_div_status        div_status;
    logic [VALUE_W-1:0] div_quotient;
    logic [RADIX_W-1:0] div_remainder;

    // digit stack hookup
    logic               stk_we, stk_re;
    logic [AW-1:0]      stk_waddr, stk_raddr;
    logic [DIGIT_W-1:0] stk_rdata;

    logic               in_accept;
    logic               out_free;
    logic               radix_bad;
    logic [LVL_W-1:0]   level_dec;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    // the result register can take a new beat this cycle
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign radix_bad = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
    assign level_dec = r_level - 1'b1;

    assign stk_waddr = r_level[AW-1:0];
    assign stk_raddr = level_dec[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_level      = r_level;
        n_radix      = r_radix;
        n_flag_empty = r_flag_empty;
        n_flag_bad   = r_flag_bad;
        n_digit      = r_digit;
        n_last       = r_last;
        n_empty      = r_empty;
        n_bad        = r_bad;
        // a waiting beat drops once taken
        n_out_valid  = r_out_valid && !i_m_axis_tready;

        o_s_axis_tready = 1'b0;
        div_start       = 1'b0;
        div_dividend    = in_value;
        stk_we          = 1'b0;
        stk_re          = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (in_accept) begin
                    n_level = '0;
                    n_radix = in_radix;
                    if (radix_bad || (in_value == '0)) begin
                        // bad radix wins over zero value
                        n_flag_bad   = radix_bad;
                        n_flag_empty = !radix_bad;
                        n_state      = ST_FLAG;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                if (div_status.done) begin
                    // push the remainder while the stack has room, then divide the quotient again until it is zero
                    if (r_level < LVL_W'(DIGIT_DEPTH)) begin
                        stk_we  = 1'b1;
                        n_level = r_level + 1'b1;
                    end
                    if (div_quotient == '0) begin
                        n_state = ST_POP_RD;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = div_quotient;
                    end
                end
            end
            ST_POP_RD: begin
                stk_re  = 1'b1;
                n_state = ST_POP_WAIT;
            end
            ST_POP_WAIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_digit     = stk_rdata;
                    n_last      = (r_level == LVL_W'(1));
                    n_empty     = 1'b0;
                    n_bad       = 1'b0;
                    n_level     = level_dec;
                    n_state     = (r_level == LVL_W'(1)) ? ST_IDLE : ST_POP_RD;
                end
            end
            ST_FLAG: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_digit     = '0;
                    n_last      = 1'b1;
                    n_empty     = r_flag_empty;
                    n_bad       = r_flag_bad;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
        r_radix      <= n_radix;
        r_flag_empty <= n_flag_empty;
        r_flag_bad   <= n_flag_bad;
        r_digit      <= n_digit;
        r_last       <= n_last;
        r_empty      <= n_empty;
        r_bad        <= n_bad;
    end

    // shared divider: radix comes from the input on the first digit, then held
    rde_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   ((r_state == ST_IDLE) ? in_radix : r_radix),
        .o_status    (div_status),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder)
    );

    // digit stack
    rde_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (div_remainder),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_digit);
    assign o_m_axis_tlast  = r_last;

    always_comb begin
        o_m_axis_tuser             = '0;
        o_m_axis_tuser[USER_EMPTY] = r_empty;
        o_m_axis_tuser[USER_BAD]   = r_bad;
    end

endmodule

// ===== design/rde_checker.sv =====
// ----------------------------------------------------------------------------
// rde_checker
// port-level checks of the radix digit emitter, bound to the top level
// ----------------------------------------------------------------------------
`include "radix_digit_emitter_top_assert.svh"

module rde_checker import rde_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                 o_m_axis_tlast,
    input logic [M_TUSER_W-1:0] o_m_axis_tuser
);

    // a stalled result beat holds
    `RDE_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))

    // an accepted input beat makes the block busy
    `RDE_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // a flagged beat is the only beat of its item and carries digit zero
    `RDE_ASSERT_NOW(a_flag_single, o_m_axis_tvalid && (o_m_axis_tuser != '0), o_m_axis_tlast && (o_m_axis_tdata == '0))

    // empty and bad radix never show together
    `RDE_ASSERT_NOW(a_flag_excl, o_m_axis_tvalid, !(o_m_axis_tuser[USER_EMPTY] && o_m_axis_tuser[USER_BAD]))

    // digits stay below the largest base
    `RDE_ASSERT_NOW(a_digit_range, o_m_axis_tvalid, o_m_axis_tdata < M_TDATA_W'(RADIX_MAX))

endmodule

bind radix_digit_emitter_top rde_checker u_rde_checker (.*);
